// ===== rtl/ttm_pkg.sv =====
package ttm_pkg;

    localparam int DEF_DATA_WIDTH = 16;
    localparam int SLOPE_W = 33;     // signed slope, magnitude up to 2^31
    localparam int NUM_W = 18;       // signed slope numerator
    localparam int VAL_W = 20;       // signed curve values
    localparam int FRAC = 15;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [2:0] {
        REG_TAPER   = 3'd0,
        REG_SOFTEN  = 3'd1,
        REG_BRAKE   = 3'd2,
        REG_CREEP   = 3'd3,
        REG_RST_FWD = 3'd4,
        REG_RST_BWD = 3'd5,
        REG_DRIVE   = 3'd6,
        REG_REGEN   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_NEUTRAL  = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2,
        DIR_UNUSED   = 2'd3
    } dir_t;

    // slope table entries, one division each
    typedef enum logic [2:0] {
        SLP_BRAKE = 3'd0,   // (brake + creep) / taper
        SLP_FWD0  = 3'd1,   // (creep - restraint_fwd) / taper
        SLP_BWD0  = 3'd2,   // (creep - restraint_bwd) / taper
        SLP_FWD1  = 3'd3,   // (drive - mid) / soften
        SLP_BWD1  = 3'd4    // (mid - regen) / soften
    } slp_t;

endpackage

// ===== rtl/throttle_torque_map.sv =====
// throttle_torque_map: torque command from gear direction, speed and throttle
//
// s_ channel carries one request per item, m_ channel one torque per item.
// cfg channel writes the eight curve registers by index; it is always ready.
// After reset and after every cfg write a shared restoring divider works out
// the five curve slopes, one quotient bit per cycle with a load step before
// and a store step after each slope; s_tready is low while it works.
// Registers restore their reset values at once.
// Five register stages (decode, slope multiply, curve sum, throttle
// multiply, blend/output register).
// Throughput: one item per cycle while neither stalled nor computing slopes;
// the multipliers set the stage depth.
// When the receiver holds m_tready low while m_tvalid is high, the whole
// pipeline freezes in place and s_tready drops; nothing is lost or repeated.
// aresetn is synchronous, active low, and empties the pipeline.
module throttle_torque_map
    import ttm_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [1:0] direction, [17:2] speed, [33:18] throttle
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] torque_out
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_addr,
    input  logic [15:0]            cfg_data
);

    // configuration registers
    logic [14:0] taper_reg, soften_reg, brake_reg, creep_reg;
    logic signed [15:0] rfwd_reg, rbwd_reg, drive_reg, regen_reg;
    logic cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taper_reg  <= 15'd1000;
            soften_reg <= 15'd500;
            brake_reg  <= '0;
            creep_reg  <= '0;
            rfwd_reg   <= '0;
            rbwd_reg   <= '0;
            drive_reg  <= '0;
            regen_reg  <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_TAPER:   taper_reg  <= cfg_data[14:0];
                REG_SOFTEN:  soften_reg <= cfg_data[14:0];
                REG_BRAKE:   brake_reg  <= cfg_data[14:0];
                REG_CREEP:   creep_reg  <= cfg_data[14:0];
                REG_RST_FWD: rfwd_reg   <= cfg_data;
                REG_RST_BWD: rbwd_reg   <= cfg_data;
                REG_DRIVE:   drive_reg  <= cfg_data;
                REG_REGEN:   regen_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // midpoint of the full-throttle limits, floor of the half sum
    logic signed [16:0] lim_sum;
    logic signed [16:0] mid;
    assign lim_sum = 17'(drive_reg) + 17'(regen_reg);
    assign mid = lim_sum >>> 1;

    // slope divider: restarts on reset and on every cfg write
    logic busy_reg;
    logic [2:0] job_reg;
    logic [5:0] bit_reg;
    logic [31:0] dnum_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic neg_reg;
    logic [14:0] dden_reg;
    logic signed [SLOPE_W-1:0] slope_reg [5];

    logic signed [NUM_W-1:0] job_num;
    logic [14:0] job_den;
    logic [NUM_W-1:0] job_mag;
    logic [15:0] rem_shift;
    logic rem_ge;
    logic [SLOPE_W-1:0] quo_ext;

    always_comb begin
        unique case (slp_t'(job_reg))
            SLP_BRAKE: begin
                job_num = NUM_W'({1'b0, brake_reg}) + NUM_W'({1'b0, creep_reg});
                job_den = taper_reg;
            end
            SLP_FWD0: begin
                job_num = NUM_W'({1'b0, creep_reg}) - NUM_W'(rfwd_reg);
                job_den = taper_reg;
            end
            SLP_BWD0: begin
                job_num = NUM_W'({1'b0, creep_reg}) - NUM_W'(rbwd_reg);
                job_den = taper_reg;
            end
            SLP_FWD1: begin
                job_num = NUM_W'(drive_reg) - NUM_W'(mid);
                job_den = soften_reg;
            end
            SLP_BWD1: begin
                job_num = NUM_W'(mid) - NUM_W'(regen_reg);
                job_den = soften_reg;
            end
            default: begin
                job_num = '0;
                job_den = '0;
            end
        endcase
        job_mag = job_num[NUM_W-1] ? NUM_W'(-job_num) : NUM_W'(job_num);
        rem_shift = {rem_reg[14:0], dnum_reg[31]};
        rem_ge = (dden_reg != 15'd0) && (rem_shift >= {1'b0, dden_reg});
        quo_ext = {1'b0, quo_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            busy_reg <= 1'b1;
            job_reg  <= SLP_BRAKE;
            bit_reg  <= '0;
        end else if (busy_reg) begin
            if (bit_reg == 6'd0) begin
                // load the next division
                dnum_reg <= {job_mag[16:0], 15'd0};
                dden_reg <= job_den;
                neg_reg  <= job_num[NUM_W-1];
                rem_reg  <= '0;
                quo_reg  <= '0;
                bit_reg  <= 6'd1;
            end else if (bit_reg <= 6'd32) begin
                dnum_reg <= {dnum_reg[30:0], 1'b0};
                rem_reg  <= rem_ge ? (rem_shift - {1'b0, dden_reg}) : rem_shift;
                quo_reg  <= {quo_reg[30:0], rem_ge};
                bit_reg  <= bit_reg + 6'd1;
            end else begin
                // store signed quotient, truncated toward zero
                slope_reg[job_reg] <= neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
                bit_reg <= '0;
                if (job_reg == SLP_BWD1) begin
                    busy_reg <= 1'b0;
                end else begin
                    job_reg <= job_reg + 3'd1;
                end
            end
        end
    end

    // pipeline advance
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign en = !v5_reg || m_tready;
    assign s_tready = !busy_reg && en;

    // stage 1: region decode
    logic [1:0] in_dir;
    logic signed [15:0] in_spd;
    logic [15:0] in_thr;
    logic signed [16:0] s17, nt17, rs17;
    logic signed [SLOPE_W-1:0] k0, k1;
    logic signed [VAL_W-1:0] c0, c1;
    logic r_pos, r_neg, r_hi, band, above;

    assign in_dir = s_tdata[1:0];
    assign in_spd = s_tdata[17:2];
    assign in_thr = s_tdata[33:18];

    always_comb begin
        s17  = 17'(in_spd);
        nt17 = $signed({2'b00, taper_reg});
        rs17 = $signed({2'b00, soften_reg});
        r_pos = (s17 >= 17'sd0) && (s17 < nt17);
        r_neg = (s17 < 17'sd0) && (s17 >= -nt17);
        r_hi  = (s17 >= nt17);
        band  = (s17 >= -rs17) && (s17 <= rs17);
        above = (s17 > rs17);
        k0 = '0;
        k1 = '0;
        c0 = '0;
        c1 = '0;
        unique case (dir_t'(in_dir))
            DIR_FORWARD: begin
                if (r_pos) begin
                    k0 = -slope_reg[SLP_BRAKE];
                    c0 = VAL_W'($signed({1'b0, creep_reg}));
                end else if (r_neg) begin
                    k0 = slope_reg[SLP_FWD0];
                    c0 = VAL_W'($signed({1'b0, creep_reg}));
                end else if (r_hi) begin
                    c0 = -VAL_W'($signed({1'b0, brake_reg}));
                end else begin
                    c0 = VAL_W'(rfwd_reg);
                end
                if (band) begin
                    k1 = slope_reg[SLP_FWD1];
                    c1 = VAL_W'(mid);
                end else if (above) begin
                    c1 = VAL_W'(drive_reg);
                end else begin
                    c1 = VAL_W'(regen_reg);
                end
            end
            DIR_BACKWARD: begin
                if (r_pos) begin
                    k0 = slope_reg[SLP_BWD0];
                    c0 = -VAL_W'($signed({1'b0, creep_reg}));
                end else if (r_neg) begin
                    k0 = -slope_reg[SLP_BRAKE];
                    c0 = -VAL_W'($signed({1'b0, creep_reg}));
                end else if (r_hi) begin
                    c0 = -VAL_W'(rbwd_reg);
                end else begin
                    c0 = VAL_W'($signed({1'b0, brake_reg}));
                end
                if (band) begin
                    k1 = slope_reg[SLP_BWD1];
                    c1 = -VAL_W'(mid);
                end else if (above) begin
                    c1 = -VAL_W'(regen_reg);
                end else begin
                    c1 = -VAL_W'(drive_reg);
                end
            end
            default: ;
        endcase
    end

    logic signed [SLOPE_W-1:0] k0_reg, k1_reg;
    logic signed [VAL_W-1:0] c0_1_reg, c1_1_reg, c0_2_reg, c1_2_reg;
    logic signed [15:0] spd1_reg;
    logic [15:0] thr1_reg, thr2_reg, thr3_reg;
    logic signed [SLOPE_W+15:0] p0_reg, p1_reg;
    logic signed [VAL_W-1:0] y0_3_reg, y0_4_reg;
    logic signed [VAL_W:0] diff_reg;
    logic signed [VAL_W+17:0] m_reg;
    logic [OUT_TDATA_W-1:0] out_reg;

    logic signed [SLOPE_W+15:0] p0_sh, p1_sh;
    logic signed [VAL_W-1:0] y0_c, y1_c;
    logic signed [VAL_W+17:0] m_sh;
    logic signed [VAL_W-1:0] t_c;
    logic [OUT_TDATA_W-1:0] out_c;

    always_comb begin
        // curve values and blend
        p0_sh = p0_reg >>> FRAC;
        p1_sh = p1_reg >>> FRAC;
        y0_c = VAL_W'(p0_sh) + c0_2_reg;
        y1_c = VAL_W'(p1_sh) + c1_2_reg;
        m_sh = m_reg >>> FRAC;
        t_c = VAL_W'(m_sh) + y0_4_reg;
        // keep the low DATA_WIDTH bits
        for (int i = 0; i < OUT_TDATA_W; i++) begin
            out_c[i] = (i < DATA_WIDTH) ? t_c[i] : 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid && s_tready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            k0_reg   <= k0;
            k1_reg   <= k1;
            c0_1_reg <= c0;
            c1_1_reg <= c1;
            spd1_reg <= in_spd;
            thr1_reg <= in_thr;
            p0_reg   <= k0_reg * spd1_reg;
            p1_reg   <= k1_reg * spd1_reg;
            c0_2_reg <= c0_1_reg;
            c1_2_reg <= c1_1_reg;
            thr2_reg <= thr1_reg;
            y0_3_reg <= y0_c;
            diff_reg <= (VAL_W+1)'(y1_c) - (VAL_W+1)'(y0_c);
            thr3_reg <= thr2_reg;
            m_reg    <= diff_reg * $signed({1'b0, thr3_reg});
            y0_4_reg <= y0_3_reg;
            out_reg  <= out_c;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("item accepted while slopes are computed");
    a_cfg_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> busy_reg && job_reg == SLP_BRAKE)
        else $error("cfg write did not restart slope computation");
    a_job_range: assert property (@(posedge aclk) disable iff (!aresetn)
        job_reg <= SLP_BWD1)
        else $error("slope job out of range");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && !m_tready) |=> v5_reg && $stable(out_reg))
        else $error("stalled output changed");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import ttm_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_addr = '0;
    logic [15:0]            cfg_data = '0;

    throttle_torque_map dut (.*);

    always #1 aclk = ~aclk;

    // predictor copy of the curve registers
    longint taper_spd, soften_spd, brake_trq, creep_trq;
    longint rst_fwd, rst_bwd, drive_lim, regen_lim;

    logic [15:0] torque_q[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          stall_mode = 1'b0;

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint q15_slope(longint x, longint d);
        if (d == 0) return 0;
        return (x * 32768) / d;
    endfunction

    function automatic logic [15:0] predict_torque(dir_t dir, logic [15:0] spd_raw,
                                                   logic [15:0] thr_raw);
        longint s, thr, y0, y1, mid, t;
        s = longint'($signed(spd_raw));
        thr = longint'(thr_raw);
        y0 = 0;
        y1 = 0;
        if (dir == DIR_FORWARD) begin
            if (s >= 0 && s < taper_spd)
                y0 = floor_shift(-q15_slope(brake_trq + creep_trq, taper_spd) * s, 15)
                     + creep_trq;
            else if (s < 0 && s >= -taper_spd)
                y0 = floor_shift(q15_slope(creep_trq - rst_fwd, taper_spd) * s, 15)
                     + creep_trq;
            else if (s >= taper_spd)
                y0 = -brake_trq;
            else
                y0 = rst_fwd;
            if (s >= -soften_spd && s <= soften_spd) begin
                mid = floor_shift(drive_lim + regen_lim, 1);
                y1 = floor_shift(q15_slope(drive_lim - mid, soften_spd) * s, 15) + mid;
            end else if (s > soften_spd) begin
                y1 = drive_lim;
            end else begin
                y1 = regen_lim;
            end
        end else if (dir == DIR_BACKWARD) begin
            if (s >= 0 && s < taper_spd)
                y0 = floor_shift(q15_slope(creep_trq - rst_bwd, taper_spd) * s, 15)
                     - creep_trq;
            else if (s < 0 && s >= -taper_spd)
                y0 = floor_shift(-q15_slope(brake_trq + creep_trq, taper_spd) * s, 15)
                     - creep_trq;
            else if (s >= taper_spd)
                y0 = -rst_bwd;
            else
                y0 = brake_trq;
            if (s >= -soften_spd && s <= soften_spd) begin
                mid = floor_shift(drive_lim + regen_lim, 1);
                y1 = floor_shift(q15_slope(mid - regen_lim, soften_spd) * s, 15) - mid;
            end else if (s > soften_spd) begin
                y1 = -regen_lim;
            end else begin
                y1 = -drive_lim;
            end
        end
        t = floor_shift((y1 - y0) * thr, 15) + y0;
        return t[15:0];
    endfunction

    function automatic void reset_regs();
        taper_spd = 1000;
        soften_spd = 500;
        brake_trq = 0;
        creep_trq = 0;
        rst_fwd = 0;
        rst_bwd = 0;
        drive_lim = 0;
        regen_lim = 0;
    endfunction

    // send one request item, with an optional idle gap first
    task automatic send_request(dir_t dir, logic [15:0] spd, logic [15:0] thr, int gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, thr, spd, dir};
        do @(posedge aclk); while (!s_tready);
        torque_q.push_back(predict_torque(dir, spd, thr));
    endtask

    // burst sender: gaps come between bursts only
    int burst_left = 0;
    task automatic send_bursty(dir_t dir, logic [15:0] spd, logic [15:0] thr);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, thr, spd, dir};
        do @(posedge aclk); while (!s_tready);
        torque_q.push_back(predict_torque(dir, spd, thr));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (torque_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TAPER:   taper_spd = longint'(val[14:0]);
            REG_SOFTEN:  soften_spd = longint'(val[14:0]);
            REG_BRAKE:   brake_trq = longint'(val[14:0]);
            REG_CREEP:   creep_trq = longint'(val[14:0]);
            REG_RST_FWD: rst_fwd = longint'($signed(val));
            REG_RST_BWD: rst_bwd = longint'($signed(val));
            REG_DRIVE:   drive_lim = longint'($signed(val));
            REG_REGEN:   regen_lim = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] v[8]);
        for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v[i]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            3: return 16'(taper_spd + $urandom_range(0, 4) - 2);
            4: return 16'(-soften_spd + $urandom_range(0, 4) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_throttle();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic dir_t rand_dir();
        return ($urandom_range(0, 9) == 0) ? dir_t'($urandom_range(0, 3))
                                           : dir_t'($urandom_range(1, 2));
    endfunction

    function automatic logic [15:0] rand_field(bit wide);
        case ($urandom_range(0, 4))
            0: return wide ? 16'h8000 : 16'd0;
            1: return wide ? 16'h7fff : 16'h7fff;
            2: return 16'($urandom_range(0, 3000));
            default: return wide ? 16'($urandom) : 16'($urandom_range(0, 32767));
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] spds[10];
        spds = '{16'h8000, 16'h7fff, 16'd0, 16'd1, 16'hffff,
                 16'd999, 16'd1000, 16'hfc18, 16'd500, 16'hfe0c};
        // every direction code including the unused one, edge speeds and throttles
        for (int d = 0; d < 4; d++)
            send_request(dir_t'(d), spds[d * 2], (d == 3) ? 16'hffff : 16'd32768, 0);
        foreach (spds[i]) send_request(DIR_FORWARD, spds[i], 16'd16384, 0);
        foreach (spds[i]) send_request(DIR_BACKWARD, spds[i], (i % 2) ? 16'd0 : 16'hffff, 0);
        drain();
    endtask

    task automatic test_random_block(int n);
        for (int i = 0; i < n; i++) send_bursty(rand_dir(), rand_speed(), rand_throttle());
        drain();
    endtask

    // receiver held off for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_request(rand_dir(), rand_speed(), rand_throttle(), 0);
        join
        drain();
    endtask

    task automatic test_settings();
        logic [15:0] v[8];
        // extreme low: smallest nonzero speeds, zero torques, most negative limits
        v = '{16'd1, 16'd1, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        write_all(v);
        test_random_block(100);
        // extreme high
        v = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        write_all(v);
        test_random_block(100);
        // mixed signs, upper bits set in unsigned fields get masked
        v = '{16'hffff, 16'h8000, 16'hffff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
        write_all(v);
        test_random_block(50);
        // typical vehicle-like settings
        v = '{16'd800, 16'd400, 16'd3000, 16'd1500, 16'd2000, 16'hf830, 16'd20000, 16'hd8f0};
        write_all(v);
        test_random_block(100);
        for (int k = 0; k < 10; k++) begin
            foreach (v[i]) v[i] = rand_field(i >= 4);
            write_all(v);
            test_random_block(100);
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
            m_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (torque_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: torque %h", m_tdata);
            end else begin
                want = torque_q.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("torque mismatch: expected %h actual %h", want, m_tdata);
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        reset_regs();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_block(200);
        test_backpressure();
        test_settings();
        drain();
        if (mismatches == 0 && torque_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
